/* hdl/utfc_pkg.sv */
// Package for the UTF-8 / 16-bit code converter: shared types and constants.
`default_nettype none
package utfc_pkg;

  // Register word index of direction_mode
  localparam logic REG_DIRECTION = 1'b0;

  // Direction codes
  localparam logic MODE_DECODE = 1'b0;
  localparam logic MODE_ENCODE = 1'b1;

  // Result queue
  localparam int QDEPTH = 4;
  localparam int QCNT_W = 3;
  localparam int MAX_RES = 3;

  // UTF-8 constants
  localparam logic [7:0]  LEAD2_MARK = 8'hC0;
  localparam logic [7:0]  LEAD3_MARK = 8'hE0;
  localparam logic [7:0]  CONT_MARK  = 8'h80;
  localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;

  // One result transaction
  typedef struct packed {
    logic [15:0] value;
    logic        last;
    logic        eos;
    logic        trunc;
  } res_t;

  // Queue status towards the input side
  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              room;
  } qstat_t;

endpackage
`default_nettype wire

/* hdl/utf8_ucs2_codec.sv */
// Top level of the UTF-8 / 16-bit code converter with its register port.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+--------------------------------
//  in_     | in  | in_tvalid / in_tready   | in_tdata: data_in
//  out_    | out | out_tvalid / out_tready | out_tdata, out_tlast, out_tuser
//  cfg_    | in  | APB, pready tied high   | direction_mode at byte addr 0
//
// Each transaction is captured in an input register, converted combinationally
// and written into a four-entry result queue whose head drives out_.
// Decode: one byte per cycle sustained while out_ takes every result (results
// of 0 or 1 per byte). Encode: 1, 2 or 3 result bytes per code, the output port
// emitting one byte per cycle; the input waits while the queue lacks room for a
// burst. Data passes the input register, then the queue register, to out_.
// Synchronous reset clears the run state, the queue and direction_mode (decode).
// A stalled output fills the queue, which then holds off the input.
`default_nettype none
module utf8_ucs2_codec
  import utfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] data_in
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] out_value
  output logic             out_tlast,  // last
  output logic [1:0]       out_tuser,  // [0] end_of_string, [1] truncated
  // register port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic        mode_r;
  logic        cfg_wr;
  logic        mode_wr;
  logic        in_vld_r;
  logic [15:0] in_data_r;
  logic        fire;
  logic [1:0]  n_res;
  res_t [MAX_RES-1:0] res;
  res_t        head;
  logic        head_vld;
  qstat_t      qstat;

  // ---- register port ----
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  // word decode only, byte offset ignored
  assign mode_wr    = cfg_wr && (cfg_paddr[2] == REG_DIRECTION);
  assign cfg_prdata = (cfg_paddr[2] == REG_DIRECTION) ? {31'h0, mode_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n)
      mode_r <= MODE_DECODE;
    else if (mode_wr)
      mode_r <= cfg_pwdata[0];
  end

  // ---- input register ----
  // the held word converts as soon as the queue can take a full burst
  assign fire      = in_vld_r && qstat.room;
  assign in_tready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n)
      in_vld_r <= 1'b0;
    else if (in_tready)
      in_vld_r <= in_tvalid;
    if (in_tready && in_tvalid)
      in_data_r <= in_tdata;
  end

  // ---- conversion ----
  utfc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .mode  (mode_r),
    .clear (mode_wr),   // a mode write drops any partial run
    .fire  (fire),
    .data  (in_data_r),
    .n_res (n_res),
    .res   (res)
  );

  // ---- result queue / output register ----
  utfc_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fire),
    .n_push   (n_res),
    .push_res (res),
    .pop      (out_tvalid && out_tready),
    .head     (head),
    .head_vld (head_vld),
    .stat     (qstat)
  );

  assign out_tvalid = head_vld;
  assign out_tdata  = head.value;
  assign out_tlast  = head.last;
  assign out_tuser  = {head.trunc, head.eos};

  // ---- assertions ----
  a_qdepth : assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_dec_single : assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (mode_r == MODE_DECODE)) |-> (n_res <= 2'd1))
    else $error("decode produced more than one result");

  a_trunc_eos : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (out_tuser[0] && out_tlast))
    else $error("truncated without terminator");

  a_eos_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == 16'h0))
    else $error("terminator with nonzero value");

endmodule
`default_nettype wire

/* hdl/utfc_core.sv */
// Conversion logic and decode run state: one input word to up to three results.
`default_nettype none
module utfc_core
  import utfc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                mode,
  input  wire logic                clear,
  input  wire logic                fire,
  input  wire logic [15:0]         data,
  output logic      [1:0]          n_res,
  output res_t      [MAX_RES-1:0]  res
);

  logic [1:0]  pend_r, pend_nxt;
  logic [1:0]  seqlen_r, seqlen_nxt;
  logic [15:0] partial_r, partial_nxt;

  always_comb begin
    logic [7:0]  b;
    logic [15:0] code;
    logic [15:0] c;
    b           = data[7:0];
    c           = data;
    code        = '0;
    pend_nxt    = pend_r;
    seqlen_nxt  = seqlen_r;
    partial_nxt = partial_r;
    n_res       = 2'd0;
    res         = '0;
    if (mode == MODE_DECODE) begin
      if (b == 8'h00) begin
        n_res       = 2'd1;
        res[0]      = '{value: 16'h0, last: 1'b1, eos: 1'b1, trunc: (pend_r != 2'd0)};
        pend_nxt    = '0;
        seqlen_nxt  = '0;
        partial_nxt = '0;
      end else if (pend_r == 2'd0) begin
        if (b < CONT_MARK) begin
          n_res  = 2'd1;
          res[0] = '{value: {9'h0, b[6:0]}, last: 1'b1, eos: 1'b0, trunc: 1'b0};
        end else begin
          seqlen_nxt  = (b < LEAD3_MARK) ? 2'd2 : 2'd3;
          pend_nxt    = (b < LEAD3_MARK) ? 2'd1 : 2'd2;
          partial_nxt = {8'h00, b};
        end
      end else if (pend_r > 2'd1) begin
        partial_nxt = {partial_r[7:0], b};
        pend_nxt    = pend_r - 2'd1;
      end else begin
        if (seqlen_r == 2'd2)
          code = {5'h00, partial_r[4:0], b[5:0]};
        else
          code = {partial_r[11:8], partial_r[5:0], b[5:0]};
        pend_nxt    = '0;
        seqlen_nxt  = '0;
        partial_nxt = '0;
        if (code != 16'h0) begin
          n_res  = 2'd1;
          res[0] = '{value: code, last: 1'b1, eos: 1'b0, trunc: 1'b0};
        end
      end
    end else begin
      if (c == 16'h0) begin
        n_res  = 2'd1;
        res[0] = '{value: 16'h0, last: 1'b1, eos: 1'b1, trunc: 1'b0};
      end else if (c < {8'h00, CONT_MARK}) begin
        n_res  = 2'd1;
        res[0] = '{value: c, last: 1'b1, eos: 1'b0, trunc: 1'b0};
      end else if (c < TWO_BYTE_LIMIT) begin
        n_res  = 2'd2;
        res[0] = '{value: {8'h00, LEAD2_MARK | {3'b000, c[10:6]}},
                   last: 1'b0, eos: 1'b0, trunc: 1'b0};
        res[1] = '{value: {8'h00, CONT_MARK | {2'b00, c[5:0]}},
                   last: 1'b1, eos: 1'b0, trunc: 1'b0};
      end else begin
        n_res  = 2'd3;
        res[0] = '{value: {8'h00, LEAD3_MARK | {4'h0, c[15:12]}},
                   last: 1'b0, eos: 1'b0, trunc: 1'b0};
        res[1] = '{value: {8'h00, CONT_MARK | {2'b00, c[11:6]}},
                   last: 1'b0, eos: 1'b0, trunc: 1'b0};
        res[2] = '{value: {8'h00, CONT_MARK | {2'b00, c[5:0]}},
                   last: 1'b1, eos: 1'b0, trunc: 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      pend_r    <= '0;
      seqlen_r  <= '0;
      partial_r <= '0;
    end else if (fire) begin
      pend_r    <= pend_nxt;
      seqlen_r  <= seqlen_nxt;
      partial_r <= partial_nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/utfc_outq.sv */
// Four-entry result queue; the head entry is the registered output.
`default_nettype none
module utfc_outq
  import utfc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire logic [1:0]          n_push,
  input  wire res_t [MAX_RES-1:0]  push_res,
  input  wire logic                pop,
  output res_t                     head,
  output logic                     head_vld,
  output qstat_t                   stat
);

  res_t [QDEPTH-1:0] q_r, q_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    logic [QCNT_W-1:0] base;
    logic [QCNT_W-1:0] off;
    base = count_r - {{(QCNT_W-1){1'b0}}, pop};
    for (int i = 0; i < QDEPTH; i++) begin
      off = QCNT_W'(i) - base;
      if (pop && (i < QDEPTH-1))
        q_nxt[i] = q_r[i+1];
      else
        q_nxt[i] = q_r[i];
      if (push && (QCNT_W'(i) >= base) && (off < {1'b0, n_push}))
        q_nxt[i] = push_res[off[1:0]];
    end
    count_nxt = base + (push ? {1'b0, n_push} : '0);
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    if (!rst_n)
      count_r <= '0;
    else
      count_r <= count_nxt;
  end

  assign head       = q_r[0];
  assign head_vld   = (count_r != '0);
  assign stat.count = count_r;
  // room for a full three-result burst even if the head is not taken
  assign stat.room  = (count_r <= QCNT_W'(QDEPTH - MAX_RES));

endmodule
`default_nettype wire
